@@ hdl/trimmed_mean_rank_filter_defines.svh @@
`ifndef TRIMMED_MEAN_RANK_FILTER_DEFINES_SVH
`define TRIMMED_MEAN_RANK_FILTER_DEFINES_SVH
// Condition that must hold at every active clock edge.
`define TMRF_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);
// Condition that must hold in the cycle after a trigger.
`define TMRF_ASSERT_NEXT(label, trig, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) else $error(msg);
`endif

@@ hdl/tmrf_pkg.sv @@
package tmrf_pkg;

	localparam int MAX_WINDOW = 7;
	localparam int MAX_LINE   = 1024;
	localparam int PIXEL_BITS = 8;

	localparam int LINES     = MAX_WINDOW - 1;
	localparam int WIN_CELLS = MAX_WINDOW * MAX_WINDOW;

	localparam int ROW_W    = 12;
	localparam int COL_W    = 10;
	localparam int WIDTH_W  = 11;
	localparam int HEIGHT_W = 13;
	localparam int WS_W     = 3;
	localparam int CNT_W    = 6;
	localparam int RANK_W   = 6;
	localparam int MAX_HEIGHT = 4096;

	localparam int LINE_AW = $clog2(MAX_LINE);
	localparam int SLOT_W  = $clog2(LINES + 1);
	localparam int CELL_W  = $clog2(WIN_CELLS);
	localparam int CELLN_W = $clog2(WIN_CELLS + 1);
	localparam int SUM_W   = PIXEL_BITS + CELLN_W;
	localparam int BIT_W   = $clog2(SUM_W);

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 13;

	localparam int S_TDATA_W = ((PIXEL_BITS + 7) / 8) * 8;
	localparam int M_TDATA_W = ((PIXEL_BITS + ROW_W + COL_W + 7) / 8) * 8;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH   = 3'd0,
		REG_IMAGE_HEIGHT  = 3'd1,
		REG_WINDOW_SIZE   = 3'd2,
		REG_AVERAGE_COUNT = 3'd3,
		REG_RANK_POSITION = 3'd4
	} cfg_reg_t;

	// Effective filter settings after clamping.
	typedef struct packed {
		logic [WS_W-1:0]    ws;
		logic [CELLN_W-1:0] n;
		logic [CELLN_W-1:0] cnt;
		logic [CELL_W-1:0]  rank;
	} filt_cfg_t;

	// One window handed from the front to the back.
	typedef struct packed {
		logic [WIN_CELLS-1:0][PIXEL_BITS-1:0] pix;
		logic [ROW_W-1:0]                     row;
		logic [COL_W-1:0]                     col;
	} win_item_t;

	function automatic filt_cfg_t eff_cfg(input logic [WS_W-1:0] ws_r,
	                                      input logic [CNT_W-1:0] cnt_r,
	                                      input logic [RANK_W-1:0] rank_r);
		filt_cfg_t f;
		logic [WS_W-1:0] ws;
		logic [2*WS_W-1:0] sq;
		logic [CNT_W-1:0] c;
		ws = ws_r;
		if (ws == '0) ws = WS_W'(1);
		if (int'(ws) > MAX_WINDOW) ws = WS_W'(MAX_WINDOW);
		if (!ws[0]) ws = ws - WS_W'(1);
		sq = (2*WS_W)'(ws) * (2*WS_W)'(ws);
		c = cnt_r;
		if (c == '0) c = CNT_W'(1);
		if (!c[0]) c = c - CNT_W'(1);
		if ((2*WS_W)'(c) > sq) c = CNT_W'(sq);
		f.ws = ws;
		f.n = CELLN_W'(sq);
		f.cnt = CELLN_W'(c);
		if ((2*WS_W)'(rank_r) > sq - (2*WS_W)'(1)) f.rank = CELL_W'(sq - (2*WS_W)'(1));
		else f.rank = CELL_W'(rank_r);
		return f;
	endfunction

endpackage

@@ hdl/tmrf_front.sv @@
module tmrf_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [tmrf_pkg::PIXEL_BITS-1:0] pixel_value,
	input  logic                         frame_start,
	input  logic [tmrf_pkg::WIDTH_W-1:0]  image_width,
	input  logic [tmrf_pkg::HEIGHT_W-1:0] image_height,
	input  tmrf_pkg::filt_cfg_t          fcfg,
	input  logic                         q_full,
	output logic                         push,
	output tmrf_pkg::win_item_t          push_item
);
	import tmrf_pkg::*;

	logic [ROW_W-1:0]  row_q;
	logic [COL_W-1:0]  col_q;
	logic [SLOT_W-1:0] rm_q;

	logic [WIDTH_W-1:0]  w;
	logic [HEIGHT_W-1:0] h;
	logic [HEIGHT_W-1:0] r, nr;
	logic [WIDTH_W-1:0]  c, nc;
	logic [SLOT_W-1:0]   m, nm;
	logic                emit;
	logic                accept, stall, advance;

	logic                  valid_s1;
	logic                  emit_s1;
	logic [PIXEL_BITS-1:0] pix_s1;
	logic [ROW_W-1:0]      row_s1;
	logic [COL_W-1:0]      col_s1;
	logic [SLOT_W-1:0]     rm_s1;
	logic [PIXEL_BITS-1:0] rd_s1 [LINES];

	logic [PIXEL_BITS-1:0] win_q  [MAX_WINDOW][MAX_WINDOW];
	logic [PIXEL_BITS-1:0] win_nx [MAX_WINDOW][MAX_WINDOW];
	logic [PIXEL_BITS-1:0] col_new [MAX_WINDOW];

	// Position of the incoming pixel and of the one after it.
	always_comb begin
		if (image_width == '0) w = WIDTH_W'(1);
		else if (int'(image_width) > MAX_LINE) w = WIDTH_W'(MAX_LINE);
		else w = image_width;
		if (image_height == '0) h = HEIGHT_W'(1);
		else if (int'(image_height) > MAX_HEIGHT) h = HEIGHT_W'(MAX_HEIGHT);
		else h = image_height;

		r = HEIGHT_W'(row_q);
		c = WIDTH_W'(col_q);
		m = rm_q;
		if (frame_start) begin
			r = '0;
			c = '0;
			m = '0;
		end
		if (c >= w) begin
			c = '0;
			r = r + HEIGHT_W'(1);
			m = (m == SLOT_W'(LINES - 1)) ? '0 : m + SLOT_W'(1);
		end
		if (r >= h) begin
			r = '0;
			m = '0;
		end
		emit = (r >= HEIGHT_W'(fcfg.ws) - HEIGHT_W'(1)) &&
		       (c >= WIDTH_W'(fcfg.ws) - WIDTH_W'(1));

		nc = c + WIDTH_W'(1);
		nr = r;
		nm = m;
		if (nc >= w) begin
			nc = '0;
			nr = r + HEIGHT_W'(1);
			nm = (m == SLOT_W'(LINES - 1)) ? '0 : m + SLOT_W'(1);
			if (nr >= h) begin
				nr = '0;
				nm = '0;
			end
		end
	end

	assign stall    = valid_s1 && emit_s1 && q_full;
	assign s_tready = !stall;
	assign accept   = s_tvalid && s_tready;
	assign advance  = valid_s1 && !stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
			rm_q <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				row_q <= ROW_W'(nr);
				col_q <= COL_W'(nc);
				rm_q <= nm;
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			emit_s1 <= emit;
			pix_s1 <= pixel_value;
			row_s1 <= ROW_W'(r);
			col_s1 <= COL_W'(c);
			rm_s1 <= m;
		end
	end

	// One line memory per buffered row; read old data before the write.
	for (genvar s = 0; s < LINES; s++) begin : g_line
		logic [PIXEL_BITS-1:0] line_mem [MAX_LINE];
		always_ff @(posedge clk) begin
			if (accept) begin
				rd_s1[s] <= line_mem[LINE_AW'(c)];
				if (m == SLOT_W'(s)) line_mem[LINE_AW'(c)] <= pixel_value;
			end
		end
	end

	// New right column: rows above the bottom come from the line memories.
	always_comb begin
		logic [WS_W-1:0]   bk;
		logic [SLOT_W:0]   src;
		for (int rr = 0; rr < MAX_WINDOW; rr++) begin
			bk = fcfg.ws - WS_W'(1) - WS_W'(rr);
			src = (SLOT_W+1)'(rm_s1) + (SLOT_W+1)'(LINES) - (SLOT_W+1)'(bk);
			if (src >= (SLOT_W+1)'(LINES)) src = src - (SLOT_W+1)'(LINES);
			if (WS_W'(rr) + WS_W'(1) < fcfg.ws) col_new[rr] = rd_s1[SLOT_W'(src)];
			else if (WS_W'(rr) + WS_W'(1) == fcfg.ws) col_new[rr] = pix_s1;
			else col_new[rr] = win_q[rr][MAX_WINDOW-1];
		end
	end

	always_comb begin
		for (int rr = 0; rr < MAX_WINDOW; rr++) begin
			for (int cc = 0; cc < MAX_WINDOW - 1; cc++) win_nx[rr][cc] = win_q[rr][cc+1];
			win_nx[rr][MAX_WINDOW-1] = col_new[rr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int rr = 0; rr < MAX_WINDOW; rr++)
				for (int cc = 0; cc < MAX_WINDOW; cc++) win_q[rr][cc] <= '0;
		end else if (advance) begin
			win_q <= win_nx;
		end
	end

	assign push = advance && emit_s1;

	always_comb begin
		for (int rr = 0; rr < MAX_WINDOW; rr++)
			for (int cc = 0; cc < MAX_WINDOW; cc++)
				push_item.pix[rr*MAX_WINDOW + cc] = win_nx[rr][cc];
		push_item.row = row_s1 - ROW_W'(fcfg.ws >> 1);
		push_item.col = col_s1 - COL_W'(fcfg.ws >> 1);
	end

endmodule

@@ hdl/tmrf_queue.sv @@
`include "trimmed_mean_rank_filter_defines.svh"
module tmrf_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  tmrf_pkg::win_item_t push_item,
	output logic                full,
	input  logic                pop,
	output logic                q_valid,
	output tmrf_pkg::win_item_t q_item
);
	import tmrf_pkg::*;

	win_item_t   slot_q [2];
	logic        wr_q, rd_q;
	logic [1:0]  count_q;

	assign full    = (count_q == 2'd2);
	assign q_valid = (count_q != 2'd0);
	assign q_item  = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			count_q <= '0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (pop) rd_q <= !rd_q;
			if (push && !pop) count_q <= count_q + 2'd1;
			else if (pop && !push) count_q <= count_q - 2'd1;
		end
	end

	`TMRF_ASSERT_ALWAYS(a_no_overflow, !(push && full && !pop), "window queue overflow")
	`TMRF_ASSERT_ALWAYS(a_no_underflow, !(pop && !q_valid), "window queue underflow")
	`TMRF_ASSERT_NEXT(a_fill_tracks, push && !pop, count_q != 2'd0, "queue lost a window")

endmodule

@@ hdl/tmrf_back.sv @@
`include "trimmed_mean_rank_filter_defines.svh"
module tmrf_back (
	input  logic                clk,
	input  logic                arst_n,
	input  tmrf_pkg::filt_cfg_t fcfg,
	input  logic                q_valid,
	input  tmrf_pkg::win_item_t q_item,
	output logic                pop,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [tmrf_pkg::M_TDATA_W-1:0] m_tdata
);
	import tmrf_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_RANK = 5'b00010,
		ST_SUM  = 5'b00100,
		ST_DIV  = 5'b01000,
		ST_DONE = 5'b10000
	} back_state_t;

	back_state_t state_q;

	logic [PIXEL_BITS-1:0] val_q [WIN_CELLS];
	logic [CELL_W-1:0]     id_q  [WIN_CELLS];
	logic                  vld_q [WIN_CELLS];
	logic [ROW_W-1:0]      row_q;
	logic [COL_W-1:0]      col_q;
	logic [CELLN_W-1:0]    step_q;

	logic [WIN_CELLS-1:0]  cmp_s1;
	logic [PIXEL_BITS-1:0] cmpv_s1;
	logic                  cmpen_s1;

	logic [PIXEL_BITS-1:0] sort_mem [WIN_CELLS];
	logic [PIXEL_BITS-1:0] rd_s1;
	logic                  rdv_s1;

	logic [SUM_W-1:0]      acc_q;
	logic [SUM_W-1:0]      quo_q;
	logic [CELLN_W-1:0]    rem_q;
	logic [BIT_W-1:0]      bit_q;

	logic                  rd_en;
	logic [CELL_W-1:0]     rd_addr;
	logic [CELL_W-1:0]     wr_addr;
	logic signed [CELLN_W+1:0] ii;
	logic [CELLN_W:0]      trial;
	logic                  load_out;

	assign pop = (state_q == ST_IDLE) && q_valid;
	assign load_out = (state_q == ST_DONE) && (!m_tvalid || m_tready);
	assign wr_addr = CELL_W'($countones(cmp_s1));

	// Run index clamped into the sorted window.
	always_comb begin
		ii = $signed((CELLN_W+2)'(fcfg.rank)) - $signed((CELLN_W+2)'(fcfg.cnt >> 1)) +
		     $signed((CELLN_W+2)'(step_q));
		if (ii < 0) rd_addr = '0;
		else if (ii > $signed((CELLN_W+2)'(fcfg.n)) - 1) rd_addr = CELL_W'(fcfg.n - CELLN_W'(1));
		else rd_addr = CELL_W'(ii);
		rd_en = (state_q == ST_SUM) && (step_q < fcfg.cnt);
		trial = {rem_q, acc_q[SUM_W-1]};
	end

	always_ff @(posedge clk) begin
		if (cmpen_s1) sort_mem[wr_addr] <= cmpv_s1;
		if (rd_en) rd_s1 <= sort_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cmpen_s1 <= 1'b0;
			rdv_s1 <= 1'b0;
			step_q <= '0;
			bit_q <= '0;
			m_tvalid <= 1'b0;
		end else begin
			rdv_s1 <= rd_en;
			if (load_out) m_tvalid <= 1'b1;
			else if (m_tready) m_tvalid <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					cmpen_s1 <= 1'b0;
					if (q_valid) begin
						step_q <= '0;
						state_q <= ST_RANK;
					end
				end
				ST_RANK: begin
					if (step_q < CELLN_W'(WIN_CELLS)) begin
						cmpen_s1 <= vld_q[0];
						step_q <= step_q + CELLN_W'(1);
					end else begin
						cmpen_s1 <= 1'b0;
						step_q <= '0;
						state_q <= ST_SUM;
					end
				end
				ST_SUM: begin
					if (step_q < fcfg.cnt) begin
						step_q <= step_q + CELLN_W'(1);
					end else begin
						bit_q <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					bit_q <= bit_q + BIT_W'(1);
					if (bit_q == BIT_W'(SUM_W - 1)) state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (load_out) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Window registers: load, then rotate so the element under test sits at slot zero.
	always_ff @(posedge clk) begin
		if (pop) begin
			for (int k = 0; k < WIN_CELLS; k++) begin
				val_q[k] <= q_item.pix[k];
				id_q[k] <= CELL_W'(k);
				vld_q[k] <= (WS_W'(k / MAX_WINDOW) < fcfg.ws) &&
				            (WS_W'(k % MAX_WINDOW) >= WS_W'(MAX_WINDOW) - fcfg.ws);
			end
			row_q <= q_item.row;
			col_q <= q_item.col;
		end else if (state_q == ST_RANK && step_q < CELLN_W'(WIN_CELLS)) begin
			for (int k = 0; k < WIN_CELLS; k++) begin
				cmp_s1[k] <= vld_q[k] && ((val_q[k] < val_q[0]) ||
				             (val_q[k] == val_q[0] && id_q[k] < id_q[0]));
				val_q[k] <= val_q[(k + 1) % WIN_CELLS];
				id_q[k] <= id_q[(k + 1) % WIN_CELLS];
				vld_q[k] <= vld_q[(k + 1) % WIN_CELLS];
			end
			cmpv_s1 <= val_q[0];
		end
	end

	// Accumulate the run, then divide one quotient bit per cycle.
	// Hold the quotient until the result register takes it.
	always_ff @(posedge clk) begin
		if (pop) begin
			acc_q <= '0;
			rem_q <= '0;
			quo_q <= '0;
		end else if (state_q == ST_DIV) begin
			acc_q <= {acc_q[SUM_W-2:0], 1'b0};
			if (trial >= (CELLN_W+1)'(fcfg.cnt)) begin
				rem_q <= CELLN_W'(trial - (CELLN_W+1)'(fcfg.cnt));
				quo_q <= {quo_q[SUM_W-2:0], 1'b1};
			end else begin
				rem_q <= CELLN_W'(trial);
				quo_q <= {quo_q[SUM_W-2:0], 1'b0};
			end
		end else begin
			if (rdv_s1) acc_q <= acc_q + SUM_W'(rd_s1);
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			m_tdata <= M_TDATA_W'({col_q, row_q, quo_q[PIXEL_BITS-1:0]});
		end
	end

	`TMRF_ASSERT_ALWAYS(a_rank_write_in_rank, !cmpen_s1 || state_q == ST_RANK,
		"rank write outside ranking")
	`TMRF_ASSERT_NEXT(a_result_shown, load_out, m_tvalid, "finished result not presented")
	`TMRF_ASSERT_ALWAYS(a_read_in_sum, !rdv_s1 || state_q == ST_SUM, "stray sorted read")

endmodule

@@ hdl/trimmed_mean_rank_filter.sv @@
// Trimmed-mean rank filter for a raster pixel stream.
// Input stream: one pixel per request in tdata, tuser set on the first pixel
// of a frame. Output stream: one request per interior pixel whose square
// window lies inside the frame; border pixels give no output.
// Configuration channel: write image width, height, window size, average
// count and rank position only while the block is idle.
// The front takes one pixel per clock unless an interior window waits on a
// full queue, keeps six line memories and the 7x7 window, and hands each
// interior window to a two-entry queue. The back ranks the window (one
// element per cycle), sums the averaged run from a small sorted memory and
// divides with a restoring divider; it pops the next window only once the
// result is passed to the output register. Border pixels pass at one per clock.
// When the receiver stalls, the finished result waits in the output register,
// the back and then the queue fill, and s_tready drops on the next interior pixel.
// Reset clears counters, window and handshake state and loads the default
// registers (1024 x 1024, window 3, average 1, rank 4); line memories need no clearing.
module trimmed_mean_rank_filter (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [tmrf_pkg::S_TDATA_W-1:0]   s_tdata,   // [7:0] pixel_value
	input  logic                             s_tuser,   // [0] frame_start
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [tmrf_pkg::M_TDATA_W-1:0]   m_tdata,   // [7:0] filtered_value,
	                                                    // [19:8] out_row, [29:20] out_col
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [tmrf_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [tmrf_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import tmrf_pkg::*;

	logic [WIDTH_W-1:0]  image_width_q;
	logic [HEIGHT_W-1:0] image_height_q;
	logic [WS_W-1:0]     window_size_q;
	logic [CNT_W-1:0]    average_count_q;
	logic [RANK_W-1:0]   rank_position_q;

	filt_cfg_t fcfg;
	logic      push, q_full, pop, q_valid;
	win_item_t push_item, q_item;

	// Always take configuration requests.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q <= WIDTH_W'(1024);
			image_height_q <= HEIGHT_W'(1024);
			window_size_q <= WS_W'(3);
			average_count_q <= CNT_W'(1);
			rank_position_q <= RANK_W'(4);
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_IMAGE_WIDTH:   image_width_q <= cfg_data[WIDTH_W-1:0];
				REG_IMAGE_HEIGHT:  image_height_q <= cfg_data[HEIGHT_W-1:0];
				REG_WINDOW_SIZE:   window_size_q <= cfg_data[WS_W-1:0];
				REG_AVERAGE_COUNT: average_count_q <= cfg_data[CNT_W-1:0];
				REG_RANK_POSITION: rank_position_q <= cfg_data[RANK_W-1:0];
				default: ;  // drop writes to unmapped indexes
			endcase
		end
	end

	// Clamp the window, run length and rank once for both halves.
	assign fcfg = eff_cfg(window_size_q, average_count_q, rank_position_q);

	tmrf_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.pixel_value  (s_tdata[PIXEL_BITS-1:0]),
		.frame_start  (s_tuser),
		.image_width  (image_width_q),
		.image_height (image_height_q),
		.fcfg         (fcfg),
		.q_full       (q_full),
		.push         (push),
		.push_item    (push_item)
	);

	tmrf_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (pop),
		.q_valid   (q_valid),
		.q_item    (q_item)
	);

	tmrf_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.fcfg     (fcfg),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule
